>>> rtl/weighted_priority_flow_arbiter_defines.svh
// Assertion macros for the weighted priority flow arbiter.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef WEIGHTED_PRIORITY_FLOW_ARBITER_DEFINES_SVH
`define WEIGHTED_PRIORITY_FLOW_ARBITER_DEFINES_SVH

`ifndef ASSERT_OFF
`define WPFA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
`define WPFA_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define WPFA_ASSERT(lbl, prop)
`define WPFA_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

>>> rtl/wpfa_pkg.sv
// Types and constants shared by the weighted priority flow arbiter.
// No dependencies.
package wpfa_pkg;

  localparam int unsigned LEN_W      = 32;
  localparam int unsigned SHIFT_W    = 5;
  localparam int unsigned THRESH_W   = 32;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 8;

  localparam logic [SHIFT_W-1:0]  RST_SHIFT_BULK = 5'd0;
  localparam logic [SHIFT_W-1:0]  RST_SHIFT_STD  = 5'd1;
  localparam logic [THRESH_W-1:0] RST_THRESHOLD  = 32'd1000000;

  typedef enum logic [1:0] {
    FLOW_BULK   = 2'd0,
    FLOW_STD    = 2'd1,
    FLOW_URGENT = 2'd2
  } flow_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WEIGHTED_MODE = 2'd0,
    REG_SHIFT_BULK    = 2'd1,
    REG_SHIFT_STD     = 2'd2,
    REG_THRESHOLD     = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic                weighted_mode;
    logic [SHIFT_W-1:0]  shift_bulk;
    logic [SHIFT_W-1:0]  shift_std;
    logic [THRESH_W-1:0] threshold;
  } cfg_t;

  typedef struct packed {
    logic             bulk_ready;
    logic             std_ready;
    logic             urgent_ready;
    logic [LEN_W-1:0] bulk_head_len;
    logic [LEN_W-1:0] std_head_len;
  } req_t;

  typedef struct packed {
    logic  grant_valid;
    flow_e granted_flow;
    logic  rebalanced;
  } res_t;

endpackage

>>> rtl/wpfa_cfg_regs.sv
// Configuration registers of the weighted priority flow arbiter.
// Depends on wpfa_pkg.
module wpfa_cfg_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  wpfa_pkg::reg_idx_e                   cfg_idx_i,
  input  logic [wpfa_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  output wpfa_pkg::cfg_t                       cfg_o
);
  import wpfa_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_WEIGHTED_MODE: cfg_d.weighted_mode = cfg_wdata_i[0];
        REG_SHIFT_BULK:    cfg_d.shift_bulk    = cfg_wdata_i[SHIFT_W-1:0];
        REG_SHIFT_STD:     cfg_d.shift_std     = cfg_wdata_i[SHIFT_W-1:0];
        REG_THRESHOLD:     cfg_d.threshold     = cfg_wdata_i[THRESH_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.weighted_mode <= 1'b0;
      cfg_q.shift_bulk    <= RST_SHIFT_BULK;
      cfg_q.shift_std     <= RST_SHIFT_STD;
      cfg_q.threshold     <= RST_THRESHOLD;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/wpfa_arb_core.sv
// Grant decision and byte counters of the weighted priority flow arbiter.
// Depends on wpfa_pkg and weighted_priority_flow_arbiter_defines.svh.
`include "weighted_priority_flow_arbiter_defines.svh"

module wpfa_arb_core #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  wpfa_pkg::cfg_t cfg_i,
  input  wpfa_pkg::req_t req_i,
  input  logic           advance_i,
  output wpfa_pkg::res_t res_o
);
  import wpfa_pkg::*;

  localparam int unsigned CMP_W = (COUNT_WIDTH > THRESH_W) ? COUNT_WIDTH : THRESH_W;

  logic [COUNT_WIDTH-1:0] bulk_q, bulk_d;
  logic [COUNT_WIDTH-1:0] std_q, std_d;
  logic [COUNT_WIDTH-1:0] svc_b, svc_s;
  logic [COUNT_WIDTH-1:0] bulk_chg, std_chg;
  logic [COUNT_WIDTH-1:0] svc_b_chg, svc_s_chg, svc_diff;
  logic                   any_low, pick_bulk, weighted_act, over;

  always_comb begin
    svc_b        = bulk_q >> cfg_i.shift_bulk;
    svc_s        = std_q >> cfg_i.shift_std;
    any_low      = req_i.bulk_ready | req_i.std_ready;
    pick_bulk    = req_i.bulk_ready & (~req_i.std_ready | (svc_b <= svc_s));
    weighted_act = cfg_i.weighted_mode & ~req_i.urgent_ready & any_low;

    bulk_chg = pick_bulk ? bulk_q + COUNT_WIDTH'(req_i.bulk_head_len) : bulk_q;
    std_chg  = pick_bulk ? std_q : std_q + COUNT_WIDTH'(req_i.std_head_len);

    svc_b_chg = bulk_chg >> cfg_i.shift_bulk;
    svc_s_chg = std_chg >> cfg_i.shift_std;
    svc_diff  = (svc_b_chg > svc_s_chg) ? svc_b_chg - svc_s_chg : svc_s_chg - svc_b_chg;
    over      = CMP_W'(svc_diff) > CMP_W'(cfg_i.threshold);

    res_o.grant_valid  = any_low | req_i.urgent_ready;
    res_o.rebalanced   = weighted_act & over;
    res_o.granted_flow = FLOW_BULK;
    if (req_i.urgent_ready) begin
      res_o.granted_flow = FLOW_URGENT;
    end else if (!cfg_i.weighted_mode) begin
      res_o.granted_flow = req_i.std_ready ? FLOW_STD : FLOW_BULK;
    end else if (any_low && !pick_bulk) begin
      res_o.granted_flow = FLOW_STD;
    end

    bulk_d = bulk_q;
    std_d  = std_q;
    if (advance_i && weighted_act) begin
      if (over) begin
        bulk_d = '0;
        std_d  = '0;
      end else begin
        bulk_d = bulk_chg;
        std_d  = std_chg;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bulk_q <= '0;
      std_q  <= '0;
    end else begin
      bulk_q <= bulk_d;
      std_q  <= std_d;
    end
  end

  `WPFA_ASSERT(rebal_only_weighted_low,
    !res_o.rebalanced || (cfg_i.weighted_mode && res_o.grant_valid &&
    res_o.granted_flow != FLOW_URGENT))
  `WPFA_ASSERT_NEXT(rebal_clears_counters, advance_i && res_o.rebalanced,
    bulk_q == '0 && std_q == '0)
  `WPFA_ASSERT_NEXT(strict_counters_hold, !cfg_i.weighted_mode || !advance_i,
    $stable(bulk_q) && $stable(std_q))

endmodule

>>> rtl/weighted_priority_flow_arbiter.sv
// Arbiter top level; uses wpfa_pkg, wpfa_cfg_regs, wpfa_arb_core and the defines header.
// An accepted item is held in the input register, then its grant in the result register.
// Throughput one item per cycle, set by the counter update between the input
// and result registers; a stalled result register stops the stage, and the input takes an
// item whenever the stage is empty or advances in the same cycle.
// Reset (asynchronous, active low) empties both stages, clears counters, loads config defaults.
`include "weighted_priority_flow_arbiter_defines.svh"

module weighted_priority_flow_arbiter #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [wpfa_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [wpfa_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // bulk_ready, std_ready, urgent_ready, bulk_head_len[31:0], std_head_len[31:0], pad
  input  logic [wpfa_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // grant_valid, granted_flow[1:0], rebalanced, pad
  output logic [wpfa_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
  import wpfa_pkg::*;

  cfg_t cfg;
  req_t req_q, req_d;
  res_t res, res_q;
  logic in_valid_q, out_valid_q, advance, in_take;

  assign advance       = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;
  assign in_take       = s_axis_tvalid & s_axis_tready;

  always_comb begin
    req_d.bulk_ready    = s_axis_tdata[0];
    req_d.std_ready     = s_axis_tdata[1];
    req_d.urgent_ready  = s_axis_tdata[2];
    req_d.bulk_head_len = s_axis_tdata[LEN_W+2:3];
    req_d.std_head_len  = s_axis_tdata[2*LEN_W+2:LEN_W+3];
  end

  wpfa_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (reg_idx_e'(cfg_idx_i)),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  wpfa_arb_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .req_i     (req_q),
    .advance_i (advance),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      req_q <= req_d;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, res_q.rebalanced, res_q.granted_flow, res_q.grant_valid};

  `WPFA_ASSERT(ready_when_out_empty, out_valid_q || s_axis_tready)
  `WPFA_ASSERT_NEXT(stalled_item_held, in_valid_q && !advance,
    in_valid_q && $stable(req_q))
  `WPFA_ASSERT_NEXT(advance_fills_output, advance, out_valid_q)

endmodule

>>> tb/tb_weighted_priority_flow_arbiter.sv
// Self-checking testbench for weighted_priority_flow_arbiter: drives requests
// and register writes, predicts each grant and compares it with the block output.
// Depends on wpfa_pkg and the weighted_priority_flow_arbiter RTL.
module tb_weighted_priority_flow_arbiter;
  timeunit 1ns;
  timeprecision 1ps;

  import wpfa_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PAD_W       = IN_DATA_W - (2 * LEN_W + 3);

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  weighted_priority_flow_arbiter u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // predictor copy of the configuration and the byte counters
  logic                arb_weighted;
  logic [SHIFT_W-1:0]  arb_shift_bulk;
  logic [SHIFT_W-1:0]  arb_shift_std;
  logic [THRESH_W-1:0] arb_threshold;
  logic [31:0]         arb_bulk_bytes;
  logic [31:0]         arb_std_bytes;

  res_t        grant_q[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned src_idle_pct   = 0;
  int unsigned snk_idle_pct   = 0;
  int unsigned stall_request  = 0;
  int unsigned stall_left     = 0;
  int unsigned n_requests     = 0;
  int unsigned n_settings     = 0;
  int unsigned n_rebalanced   = 0;
  int unsigned n_empty        = 0;
  int unsigned n_flow[3]      = '{0, 0, 0};

  function automatic res_t arbitrate(input req_t r);
    res_t        g;
    logic [31:0] svc_b;
    logic [31:0] svc_s;
    logic [31:0] hi;
    logic [31:0] lo;
    g.grant_valid  = 1'b0;
    g.granted_flow = FLOW_BULK;
    g.rebalanced   = 1'b0;
    if (!arb_weighted) begin
      if (r.urgent_ready) begin
        g.grant_valid  = 1'b1;
        g.granted_flow = FLOW_URGENT;
      end else if (r.std_ready) begin
        g.grant_valid  = 1'b1;
        g.granted_flow = FLOW_STD;
      end else if (r.bulk_ready) begin
        g.grant_valid  = 1'b1;
        g.granted_flow = FLOW_BULK;
      end
    end else if (r.urgent_ready) begin
      g.grant_valid  = 1'b1;
      g.granted_flow = FLOW_URGENT;
    end else if (r.bulk_ready || r.std_ready) begin
      svc_b = arb_bulk_bytes >> arb_shift_bulk;
      svc_s = arb_std_bytes >> arb_shift_std;
      g.grant_valid = 1'b1;
      if (r.bulk_ready && (!r.std_ready || svc_b <= svc_s)) begin
        g.granted_flow = FLOW_BULK;
        arb_bulk_bytes = arb_bulk_bytes + r.bulk_head_len;
      end else begin
        g.granted_flow = FLOW_STD;
        arb_std_bytes  = arb_std_bytes + r.std_head_len;
      end
      svc_b = arb_bulk_bytes >> arb_shift_bulk;
      svc_s = arb_std_bytes >> arb_shift_std;
      hi = (svc_b > svc_s) ? svc_b : svc_s;
      lo = (svc_b > svc_s) ? svc_s : svc_b;
      if (hi - lo > arb_threshold) begin
        arb_bulk_bytes = '0;
        arb_std_bytes  = '0;
        g.rebalanced   = 1'b1;
      end
    end
    if (g.grant_valid) n_flow[g.granted_flow]++;
    else n_empty++;
    if (g.rebalanced) n_rebalanced++;
    return g;
  endfunction

  function automatic void flag_error(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("ERROR @%0t: %s", $realtime, what);
  endfunction

  function automatic logic [SHIFT_W-1:0] pick_shift();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return SHIFT_W'($urandom_range(10));
    endcase
  endfunction

  function automatic logic [LEN_W-1:0] pick_len();
    case ($urandom_range(9))
      5, 6, 7: return $urandom;
      8:       return '0;
      9:       return '1;
      default: return LEN_W'($urandom_range(4095));
    endcase
  endfunction

  // present one request, hold it until accepted, queue its predicted grant
  task automatic request(input logic b, input logic s, input logic u,
                         input logic [LEN_W-1:0] blen, input logic [LEN_W-1:0] slen);
    req_t r;
    r.bulk_ready    = b;
    r.std_ready     = s;
    r.urgent_ready  = u;
    r.bulk_head_len = blen;
    r.std_head_len  = slen;
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{PAD_W{1'b0}}, r.std_head_len, r.bulk_head_len,
                      r.urgent_ready, r.std_ready, r.bulk_ready};
    do @(posedge clk_i); while (!s_axis_tready);
    grant_q.push_back(arbitrate(r));
    n_requests++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic put_reg(input reg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_WEIGHTED_MODE: arb_weighted   = val[0];
      REG_SHIFT_BULK:    arb_shift_bulk = val[SHIFT_W-1:0];
      REG_SHIFT_STD:     arb_shift_std  = val[SHIFT_W-1:0];
      REG_THRESHOLD:     arb_threshold  = val[THRESH_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_config(input logic mode, input logic [SHIFT_W-1:0] sb,
                             input logic [SHIFT_W-1:0] ss, input logic [THRESH_W-1:0] thr);
    drain();
    put_reg(REG_WEIGHTED_MODE, CFG_DATA_W'(mode));
    put_reg(REG_SHIFT_BULK, CFG_DATA_W'(sb));
    put_reg(REG_SHIFT_STD, CFG_DATA_W'(ss));
    put_reg(REG_THRESHOLD, CFG_DATA_W'(thr));
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  task automatic shuffle_config();
    logic                mode;
    logic [SHIFT_W-1:0]  sb;
    logic [SHIFT_W-1:0]  ss;
    logic [THRESH_W-1:0] thr;
    mode = ($urandom_range(99) < 80);
    sb   = pick_shift();
    ss   = pick_shift();
    case ($urandom_range(5))
      0:       thr = '0;
      1, 2:    thr = THRESH_W'($urandom_range(5000));
      3:       thr = $urandom;
      4:       thr = '1;
      default: thr = RST_THRESHOLD;
    endcase
    load_config(mode, sb, ss, thr);
  endtask

  task automatic test_strict_priority();
    logic [2:0] combo;
    for (int i = 0; i < 8; i++) begin
      combo = 3'(i);
      request(combo[0], combo[1], combo[2], (i % 2) ? '1 : '0, (i % 2) ? '0 : '1);
    end
  endtask

  task automatic test_weighted_service();
    load_config(1'b1, '0, '0, '1);
    request(1'b0, 1'b0, 1'b0, '1, '1);
    request(1'b1, 1'b1, 1'b1, '1, '1);
    request(1'b1, 1'b1, 1'b0, 32'd5, 32'd7);
    request(1'b1, 1'b1, 1'b0, 32'd9, '1);
    request(1'b0, 1'b1, 1'b0, '0, 32'd2);
    request(1'b1, 1'b0, 1'b0, '1, '0);
    load_config(1'b1, '1, '1, '0);
    request(1'b1, 1'b1, 1'b0, 32'd3, 32'd3);
    request(1'b1, 1'b0, 1'b0, 32'h8000_0000, '0);
    request(1'b0, 1'b1, 1'b0, '0, '1);
    request(1'b0, 1'b0, 1'b1, '1, '1);
    // all-ones service measure still competes
    load_config(1'b1, '0, '0, '1);
    request(1'b1, 1'b0, 1'b0, '1, '0);
    request(1'b1, 1'b1, 1'b0, '0, 32'd1);
    request(1'b0, 1'b1, 1'b0, '0, 32'hFFFF_FFFE);
    request(1'b1, 1'b1, 1'b0, 32'd4, 32'd4);
    request(1'b1, 1'b1, 1'b0, '0, '0);
  endtask

  task automatic test_backpressure();
    src_idle_pct  = 0;
    snk_idle_pct  = 0;
    stall_request = 300;
    for (int i = 0; i < 20; i++)
      request(1'($urandom), 1'($urandom), ($urandom_range(3) == 0), pick_len(), pick_len());
  endtask

  task automatic test_random_traffic(input int unsigned n_items);
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i % 45 == 0) shuffle_config();
      request(1'($urandom), 1'($urandom), ($urandom_range(99) < 20), pick_len(), pick_len());
    end
  endtask

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d grants outstanding", cycle_count, grant_q.size());
    $display("simulation failed");
    $finish;
  end

  // receiver: random stalls, plus a long hold when one is requested
  always @(posedge clk_i) begin
    if (stall_request != 0) begin
      stall_left    = stall_request;
      stall_request = 0;
    end
    if (stall_left != 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    res_t       want;
    logic       got_v;
    logic [1:0] got_f;
    logic       got_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_v = m_axis_tdata[0];
      got_f = m_axis_tdata[2:1];
      got_r = m_axis_tdata[3];
      if (grant_q.size() == 0) begin
        flag_error($sformatf("unexpected grant valid=%0b flow=%0d rebal=%0b",
                             got_v, got_f, got_r));
      end else begin
        want = grant_q.pop_front();
        if (got_v !== want.grant_valid || got_f !== want.granted_flow ||
            got_r !== want.rebalanced)
          flag_error($sformatf("expected valid=%0b flow=%0d rebal=%0b, got valid=%0b flow=%0d rebal=%0b",
                               want.grant_valid, want.granted_flow, want.rebalanced,
                               got_v, got_f, got_r));
      end
    end
  end

  initial begin
    arb_weighted   = 1'b0;
    arb_shift_bulk = RST_SHIFT_BULK;
    arb_shift_std  = RST_SHIFT_STD;
    arb_threshold  = RST_THRESHOLD;
    arb_bulk_bytes = '0;
    arb_std_bytes  = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_idle_pct = 36;
    snk_idle_pct = 63;
    test_strict_priority();
    test_weighted_service();
    test_random_traffic(270);
    drain();
    test_backpressure();
    src_idle_pct = 63;
    snk_idle_pct = 36;
    test_random_traffic(270);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random_traffic(270);
    drain();
    repeat (8) @(posedge clk_i);

    $display("covered %0d requests under %0d register settings, %0d mismatches",
             n_requests, n_settings, mismatch_count);
    $display("grants: bulk %0d, standard %0d, urgent %0d, none %0d; rebalances %0d",
             n_flow[FLOW_BULK], n_flow[FLOW_STD], n_flow[FLOW_URGENT], n_empty, n_rebalanced);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
